// File: rtl/core/olpi_pkg.sv
// shared types and codes for the ordered list block
`timescale 1ns / 1ps

package olpi_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_PUSH   = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_INSERT = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_NOKEY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic    load_in;     // latch a new word, clear status and popped value
        logic    set_st;      // load st into the working status
        status_t st;
        logic    wr_push;     // write value at the rear, count up
        logic    rd_rear;     // read entry count-1
        logic    take_pop;    // popped value from read data, count down
        logic    idx_clr;     // search index to front
        logic    rd_search;   // read entry at search index
        logic    sch_next;    // search index up
        logic    found;       // keep match position, index to count
        logic    rd_shift;    // read entry idx-1
        logic    wr_shift;    // write read data at idx, index down
        logic    wr_ins;      // write value at match position, count up
        logic    rd_front;    // read entry 0
        logic    take_front;  // keep front from read data
        logic    load_out;    // build the result word
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic is_full;
        logic is_empty;
        logic at_end;   // search index reached count
        logic match;    // read data equals key
        logic at_pos;   // shift index reached match position
    } dp_sts_t;

endpackage

// File: rtl/core/olpi_cmd_if.sv
// request channel of the ordered list block
`timescale 1ns / 1ps

interface olpi_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] value;
    logic signed [31:0] key;

    modport source (output valid, output op, output value, output key, input ready);
    modport sink (input valid, input op, input value, input key, output ready);
endinterface

// File: rtl/core/olpi_rsp_if.sv
// result channel of the ordered list block
`timescale 1ns / 1ps

interface olpi_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic [4:0]         entry_count;

    modport source (output valid, output status, output popped_value, output front_value,
                    output rear_value, output entry_count, input ready);
    modport sink (input valid, input status, input popped_value, input front_value,
                  input rear_value, input entry_count, output ready);
endinterface

// File: rtl/core/olpi_datapath.sv
// list storage, count, search index and result registers
`timescale 1ns / 1ps

module olpi_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  olpi_pkg::dp_cmd_t        cmd,
    output olpi_pkg::dp_sts_t        sts,
    input  olpi_pkg::op_t            in_op,
    input  logic signed [31:0]       in_value,
    input  logic signed [31:0]       in_key,
    output olpi_pkg::status_t        out_status,
    output logic signed [31:0]       out_popped,
    output logic signed [31:0]       out_front,
    output logic signed [31:0]       out_rear,
    output logic [4:0]               out_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0] mem [CAPACITY];
    logic [31:0] rdata_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg;

    olpi_pkg::op_t     op_reg;
    logic [31:0]       value_reg;
    logic [31:0]       key_reg;
    olpi_pkg::status_t st_reg;
    logic [31:0]       popped_reg;
    logic [31:0]       front_reg;

    olpi_pkg::status_t o_status_reg;
    logic [31:0]       o_popped_reg;
    logic [31:0]       o_front_reg;
    logic [31:0]       o_rear_reg;
    logic [4:0]        o_count_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [CW+4:0] count_ext;

    always_comb
    begin
        rd_en   = cmd.rd_rear | cmd.rd_search | cmd.rd_shift | cmd.rd_front;
        rd_addr = '0;
        if (cmd.rd_rear)
        begin
            rd_addr = count_reg[AW-1:0] - AW'(1);
        end
        else if (cmd.rd_search)
        begin
            rd_addr = idx_reg;
        end
        else if (cmd.rd_shift)
        begin
            rd_addr = idx_reg - AW'(1);
        end
    end

    always_comb
    begin
        wr_en   = cmd.wr_push | cmd.wr_shift | cmd.wr_ins;
        wr_addr = count_reg[AW-1:0];
        wr_data = value_reg;
        if (cmd.wr_shift)
        begin
            wr_addr = idx_reg;
            wr_data = rdata_reg;
        end
        else if (cmd.wr_ins)
        begin
            wr_addr = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_push || cmd.wr_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.take_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.sch_next)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else if (cmd.found)
        begin
            idx_next = count_reg[AW-1:0];
        end
        else if (cmd.wr_shift)
        begin
            idx_next = idx_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.found)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.load_in)
        begin
            op_reg     <= in_op;
            value_reg  <= in_value;
            key_reg    <= in_key;
            st_reg     <= olpi_pkg::ST_OK;
            popped_reg <= '0;
        end
        else
        begin
            if (cmd.set_st)
            begin
                st_reg <= cmd.st;
            end
            if (cmd.take_pop)
            begin
                popped_reg <= rdata_reg;
            end
        end
        if (cmd.take_front)
        begin
            front_reg <= rdata_reg;
        end
        if (cmd.load_out)
        begin
            o_status_reg <= st_reg;
            o_popped_reg <= popped_reg;
            o_front_reg  <= (count_reg != '0) ? front_reg : '0;
            o_rear_reg   <= (count_reg != '0) ? rdata_reg : '0;
            o_count_reg  <= count_ext[4:0];
        end
    end

    // count masked to the five result bits at any capacity
    assign count_ext = {5'b0, count_reg};

    assign sts.op       = op_reg;
    assign sts.is_full  = (count_reg == CW'(CAPACITY));
    assign sts.is_empty = (count_reg == '0);
    assign sts.at_end   = (CW'(idx_reg) == count_reg);
    assign sts.match    = (rdata_reg == key_reg);
    assign sts.at_pos   = (idx_reg == pos_reg);

    assign out_status = o_status_reg;
    assign out_popped = o_popped_reg;
    assign out_front  = o_front_reg;
    assign out_rear   = o_rear_reg;
    assign out_count  = o_count_reg;

endmodule

// File: rtl/core/olpi_ctrl.sv
// sequencing state machine for the ordered list block
`timescale 1ns / 1ps

module olpi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  olpi_pkg::dp_sts_t sts,
    output olpi_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_POPW     = 4'd2;
    localparam logic [3:0] S_SREAD    = 4'd3;
    localparam logic [3:0] S_SCMP     = 4'd4;
    localparam logic [3:0] S_SHRD     = 4'd5;
    localparam logic [3:0] S_SHWR     = 4'd6;
    localparam logic [3:0] S_RDF      = 4'd7;
    localparam logic [3:0] S_RDR      = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RDF;
                case (sts.op)
                    olpi_pkg::OP_PUSH:
                    begin
                        if (sts.is_full)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = olpi_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_push = 1'b1;
                        end
                    end
                    olpi_pkg::OP_POP:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = olpi_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_rear = 1'b1;
                            state_next  = S_POPW;
                        end
                    end
                    olpi_pkg::OP_INSERT:
                    begin
                        if (sts.is_full)
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = olpi_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SREAD;
                        end
                    end
                    default:
                    begin
                        state_next = S_RDF;
                    end
                endcase
            end
            S_POPW:
            begin
                cmd.take_pop = 1'b1;
                state_next   = S_RDF;
            end
            S_SREAD:
            begin
                if (sts.at_end)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = olpi_pkg::ST_NOKEY;
                    state_next = S_RDF;
                end
                else
                begin
                    cmd.rd_search = 1'b1;
                    state_next    = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (sts.match)
                begin
                    cmd.found  = 1'b1;
                    state_next = S_SHRD;
                end
                else
                begin
                    cmd.sch_next = 1'b1;
                    state_next   = S_SREAD;
                end
            end
            S_SHRD:
            begin
                if (sts.at_pos)
                begin
                    cmd.wr_ins = 1'b1;
                    state_next = S_RDF;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHRD;
            end
            S_RDF:
            begin
                cmd.rd_front = 1'b1;
                state_next   = S_RDR;
            end
            S_RDR:
            begin
                cmd.take_front = 1'b1;
                cmd.rd_rear    = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/ordered_list_push_pop_insert.sv
// top level of the bounded ordered list with push, pop and insert before key
`timescale 1ns / 1ps

// usage
//   cmd channel takes one request word: op (push, pop, insert), value, key
//   rsp channel returns one result word per request: status, popped value,
//   front entry, rear entry and entry count after the operation
//   requests are taken one at a time; cmd.ready is high while no request is
//   in progress, also while an earlier result still waits on rsp
// steps from accept to result shown (store read port paces every step)
//   every request: dispatch, read front, read rear, result; pop adds a
//   step for the popped entry; insert reads and compares each entry up to
//   the match, moves each entry from the match on towards the rear, then
//   writes the value at the match; a missing key reads every entry held
// reset
//   rst_n clears the count and the state machine; the list starts empty
//   and the store contents are never cleared; reads past the count happen
//   only on an empty list, whose front and rear are shown as zero
// stalls
//   the result sits in an output register until rsp.ready; the next request
//   is accepted and worked on meanwhile, and it waits in its last step only
//   if the previous result has not been taken yet

module ordered_list_push_pop_insert #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    olpi_cmd_if.sink    cmd,
    olpi_rsp_if.source  rsp
);

    olpi_pkg::dp_cmd_t dp_cmd;
    olpi_pkg::dp_sts_t dp_sts;

    // sequencing of reads and writes to the single store
    olpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // store, count, index and result word
    olpi_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .in_op      (cmd.op),
        .in_value   (cmd.value),
        .in_key     (cmd.key),
        .out_status (rsp.status),
        .out_popped (rsp.popped_value),
        .out_front  (rsp.front_value),
        .out_rear   (rsp.rear_value),
        .out_count  (rsp.entry_count)
    );

endmodule

// File: rtl/core/olpi_checker.sv
// port level checks for the ordered list block, bound to the top level
`timescale 1ns / 1ps

module olpi_checker #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_popped,
    input logic [31:0] rsp_front,
    input logic [31:0] rsp_rear,
    input logic [4:0]  rsp_count
);

    // a result word holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped before taken");

    // one request in progress at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("request accepted while another in progress");

    // count never beyond capacity, checked for capacities up to 31
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CAPACITY > 31 || rsp_count <= 5'(CAPACITY)))
        else $error("entry count beyond capacity");

    // empty list reads zero at both ends, checked for capacities below 32
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_count == 5'd0 && CAPACITY < 32
            |-> rsp_front == 32'd0 && rsp_rear == 32'd0)
        else $error("empty list shows nonzero entries");

    // popped value only with a good status
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != olpi_pkg::ST_OK |-> rsp_popped == 32'd0)
        else $error("popped value on a failed request");

endmodule

bind ordered_list_push_pop_insert olpi_checker #(
    .CAPACITY (CAPACITY)
) u_olpi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_popped (rsp.popped_value),
    .rsp_front  (rsp.front_value),
    .rsp_rear   (rsp.rear_value),
    .rsp_count  (rsp.entry_count)
);
